// File: rtl/core/assert_macros.svh
// Assertion macros for the RTL files of the text layout block; the placement stage uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is held.
`define BFTL_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define BFTL_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/bftl_pkg.sv
// Types, constants and a helper function of the bitmap font text layout block.
package bftl_pkg;

    localparam int GLYPH_COUNT_DEF = 128;

    localparam int REQ_W     = 2;
    localparam int CHAR_W    = 7;
    localparam int ATLAS_W   = 12;
    localparam int SIZE_W    = 8;
    localparam int OFS_W     = 8;
    localparam int ADV_W     = 8;
    localparam int POS_W     = 24;
    localparam int SCALE_W   = 16;
    localparam int STEP_W    = 20;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 24;

    // Glyph table address compare width: covers char codes and up to 256 entries
    localparam int CMP_W     = 9;

    // Product and sum widths
    localparam int PROD_W    = OFS_W + SCALE_W + 1;   // signed offset times scale
    localparam int ADVM_W    = ADV_W + 3;             // advance times up to five
    localparam int ADVP_W    = ADVM_W + SCALE_W;      // scaled pen advance
    localparam int SUM_W     = PROD_W + 2;            // origin + pen + offset
    localparam int SAT_IN_W  = ADVP_W + 2;            // widest value fed to saturation

    // Request types
    localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_START = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CHAR  = 2'd2;

    // Character codes with special handling
    localparam logic [CHAR_W-1:0] CODE_TAB        = 7'd9;
    localparam logic [CHAR_W-1:0] CODE_NEWLINE    = 7'd10;
    localparam logic [CHAR_W-1:0] CODE_SPACE      = 7'd32;
    localparam logic [CHAR_W-1:0] CODE_UNDERSCORE = 7'd95;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_SCALE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ADVANCE_SCALE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_STEP     = 3'd4;

    // Configuration reset values
    localparam logic [SCALE_W-1:0] GLYPH_SCALE_RST   = 16'd256;
    localparam logic [SCALE_W-1:0] ADVANCE_SCALE_RST = 16'd205;
    localparam logic [STEP_W-1:0]  LINE_STEP_RST     = 20'd4096;

    typedef enum logic [2:0] {
        OP_START,
        OP_NEWLINE,
        OP_SPACE,
        OP_TAB,
        OP_GLYPH
    } op_t;

    typedef struct packed {
        logic        [ATLAS_W-1:0] atlas_x;
        logic        [ATLAS_W-1:0] atlas_y;
        logic        [SIZE_W-1:0]  width;
        logic        [SIZE_W-1:0]  height;
        logic signed [OFS_W-1:0]   offset_x;
        logic signed [OFS_W-1:0]   offset_y;
        logic        [ADV_W-1:0]   advance;
    } glyph_t;

    typedef struct packed {
        logic signed [POS_W-1:0]   origin_x;
        logic signed [POS_W-1:0]   origin_y;
        logic        [SCALE_W-1:0] glyph_scale;
        logic        [SCALE_W-1:0] advance_scale;
        logic        [STEP_W-1:0]  line_step;
    } cfg_t;

    // Lookup stage to scale stage
    typedef struct packed {
        logic   valid;
        op_t    op;
        glyph_t glyph;
    } lk_t;

    // Scale stage to placement stage
    typedef struct packed {
        logic                      valid;
        op_t                       op;
        logic signed [PROD_W-1:0]  prod_x;
        logic signed [PROD_W-1:0]  prod_y;
        logic        [POS_W-1:0]   size_w;
        logic        [POS_W-1:0]   size_h;
        logic        [ADVP_W-1:0]  adv_prod;
        logic        [ATLAS_W-1:0] atlas_x;
        logic        [ATLAS_W-1:0] atlas_y;
        logic        [SIZE_W-1:0]  atlas_w;
        logic        [SIZE_W-1:0]  atlas_h;
    } sc_t;

    // Clamp to the signed 24-bit screen range.
    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SAT_IN_W-1:0] v);
        logic [SAT_IN_W-POS_W:0] top;
        logic signed [POS_W-1:0] r;
        top = v[SAT_IN_W-1:POS_W-1];
        if ((&top) || !(|top)) begin
            r = v[POS_W-1:0];
        end
        else if (v[SAT_IN_W-1]) begin
            r = {1'b1, {(POS_W-1){1'b0}}};
        end
        else begin
            r = {1'b0, {(POS_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

// File: rtl/core/bftl_if.sv
// Channel interfaces: layout requests, screen quads and configuration writes.
interface bftl_req_if
    import bftl_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic        [REQ_W-1:0]   req_type;
    logic        [CHAR_W-1:0]  char_code;
    logic        [ATLAS_W-1:0] load_atlas_x;
    logic        [ATLAS_W-1:0] load_atlas_y;
    logic        [SIZE_W-1:0]  load_width;
    logic        [SIZE_W-1:0]  load_height;
    logic signed [OFS_W-1:0]   load_offset_x;
    logic signed [OFS_W-1:0]   load_offset_y;
    logic        [ADV_W-1:0]   load_advance;

    modport source (
        output valid, req_type, char_code, load_atlas_x, load_atlas_y, load_width,
               load_height, load_offset_x, load_offset_y, load_advance,
        input  ready
    );
    modport sink (
        input  valid, req_type, char_code, load_atlas_x, load_atlas_y, load_width,
               load_height, load_offset_x, load_offset_y, load_advance,
        output ready
    );
endinterface

interface bftl_quad_if
    import bftl_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [POS_W-1:0]   screen_x;
    logic signed [POS_W-1:0]   screen_y;
    logic        [POS_W-1:0]   screen_w;
    logic        [POS_W-1:0]   screen_h;
    logic        [ATLAS_W-1:0] atlas_x;
    logic        [ATLAS_W-1:0] atlas_y;
    logic        [SIZE_W-1:0]  atlas_w;
    logic        [SIZE_W-1:0]  atlas_h;

    modport source (
        output valid, screen_x, screen_y, screen_w, screen_h, atlas_x, atlas_y,
               atlas_w, atlas_h,
        input  ready
    );
    modport sink (
        input  valid, screen_x, screen_y, screen_w, screen_h, atlas_x, atlas_y,
               atlas_w, atlas_h,
        output ready
    );
endinterface

interface bftl_cfg_if
    import bftl_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/core/bftl_ram.sv
// Generic simple dual-port RAM with registered read.
module bftl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// File: rtl/core/bftl_lookup.sv
// Request decode, glyph table write and glyph read stage.
module bftl_lookup
    import bftl_pkg::*;
#(
    parameter int GLYPH_COUNT = GLYPH_COUNT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    bftl_req_if.sink    req,
    input  logic        lk_take,
    output lk_t         lk
);
    localparam int AW    = $clog2(GLYPH_COUNT);
    localparam int SLOTS = 1 << AW;

    logic              s1_valid_reg;
    logic              s1_valid_next;
    op_t               op_reg;
    op_t               op_next;
    logic              hit_reg;
    logic [SLOTS-1:0]  written_reg;
    logic              accept;
    logic              keep;
    logic [CHAR_W-1:0] rd_code;
    logic [CMP_W-1:0]  rd_wide;
    logic [CMP_W-1:0]  wr_wide;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic              rd_in_range;
    logic              wr_in_range;
    logic              we;
    logic              re;
    glyph_t            wr_glyph;
    glyph_t            rd_glyph;

    assign req.ready = !s1_valid_reg || lk_take;
    assign accept    = req.valid && req.ready;
    assign keep      = (req.req_type == REQ_START) || (req.req_type == REQ_CHAR);

    // Decode the character into an operation; space and tab read the underscore
    always_comb
    begin
        op_next = OP_GLYPH;
        rd_code = req.char_code;
        if (req.req_type == REQ_START)
        begin
            op_next = OP_START;
        end
        else
        begin
            case (req.char_code)
                CODE_NEWLINE: op_next = OP_NEWLINE;
                CODE_SPACE:
                begin
                    op_next = OP_SPACE;
                    rd_code = CODE_UNDERSCORE;
                end
                CODE_TAB:
                begin
                    op_next = OP_TAB;
                    rd_code = CODE_UNDERSCORE;
                end
                default: op_next = OP_GLYPH;
            endcase
        end
    end

    assign rd_wide     = CMP_W'(rd_code);
    assign wr_wide     = CMP_W'(req.char_code);
    assign rd_in_range = rd_wide < CMP_W'(GLYPH_COUNT);
    assign wr_in_range = wr_wide < CMP_W'(GLYPH_COUNT);
    assign rd_addr     = rd_wide[AW-1:0];
    assign wr_addr     = wr_wide[AW-1:0];

    assign we = accept && (req.req_type == REQ_LOAD) && wr_in_range;
    assign re = accept && keep;

    assign wr_glyph.atlas_x  = req.load_atlas_x;
    assign wr_glyph.atlas_y  = req.load_atlas_y;
    assign wr_glyph.width    = req.load_width;
    assign wr_glyph.height   = req.load_height;
    assign wr_glyph.offset_x = req.load_offset_x;
    assign wr_glyph.offset_y = req.load_offset_y;
    assign wr_glyph.advance  = req.load_advance;

    bftl_ram #(
        .WIDTH ($bits(glyph_t)),
        .DEPTH (GLYPH_COUNT)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (wr_addr),
        .wdata (wr_glyph),
        .re    (re),
        .raddr (rd_addr),
        .rdata (rd_glyph)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = keep;
        end
        else if (lk_take)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // Entries never written read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            written_reg  <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (we)
            begin
                written_reg[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            op_reg  <= op_next;
            hit_reg <= rd_in_range && written_reg[rd_addr];
        end
    end

    assign lk.valid = s1_valid_reg;
    assign lk.op    = op_reg;
    assign lk.glyph = hit_reg ? rd_glyph : '0;
endmodule

// File: rtl/core/bftl_scale.sv
// Scaling stage: offsets, sizes and pen advance times the Q8.8 scales.
module bftl_scale
    import bftl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  lk_t  lk,
    output logic lk_take,
    input  cfg_t cfg,
    output sc_t  sc,
    input  logic sc_take
);
    logic                     load;
    logic        [ADVM_W-1:0] adv_base;
    logic        [ADVM_W-1:0] adv_mult;
    logic signed [PROD_W-1:0] prod_x_next;
    logic signed [PROD_W-1:0] prod_y_next;
    logic signed [PROD_W-1:0] gscale;
    sc_t                      sc_reg;

    assign lk_take = !sc_reg.valid || sc_take;
    assign load    = lk.valid && lk_take;

    // Tab moves five underscore advances: 4x + x
    assign adv_base = ADVM_W'(lk.glyph.advance);
    assign adv_mult = (lk.op == OP_TAB) ? ((adv_base << 2) + adv_base) : adv_base;

    assign gscale      = $signed(PROD_W'(cfg.glyph_scale));
    assign prod_x_next = PROD_W'(lk.glyph.offset_x) * gscale;
    assign prod_y_next = PROD_W'(lk.glyph.offset_y) * gscale;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sc_reg <= '0;
        end
        else
        begin
            if (lk_take)
            begin
                sc_reg.valid <= lk.valid;
            end
            if (load)
            begin
                sc_reg.op       <= lk.op;
                sc_reg.prod_x   <= prod_x_next;
                sc_reg.prod_y   <= prod_y_next;
                sc_reg.size_w   <= POS_W'(lk.glyph.width) * POS_W'(cfg.glyph_scale);
                sc_reg.size_h   <= POS_W'(lk.glyph.height) * POS_W'(cfg.glyph_scale);
                sc_reg.adv_prod <= ADVP_W'(adv_mult) * ADVP_W'(cfg.advance_scale);
                sc_reg.atlas_x  <= lk.glyph.atlas_x;
                sc_reg.atlas_y  <= lk.glyph.atlas_y;
                sc_reg.atlas_w  <= lk.glyph.width;
                sc_reg.atlas_h  <= lk.glyph.height;
            end
        end
    end

    assign sc = sc_reg;
endmodule

// File: rtl/core/bftl_place.sv
// Placement stage: pen update, saturated quad position and output register.
module bftl_place
    import bftl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  sc_t         sc,
    output logic        sc_take,
    input  cfg_t        cfg,
    bftl_quad_if.source quad
);
    `include "assert_macros.svh"

    logic signed [POS_W-1:0]    pen_x_reg;
    logic signed [POS_W-1:0]    pen_x_next;
    logic signed [POS_W-1:0]    pen_y_reg;
    logic signed [POS_W-1:0]    pen_y_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic                       quad_free;
    logic                       sc_fire;
    logic                       emit;
    logic signed [SUM_W-1:0]    sum_x;
    logic signed [SUM_W-1:0]    sum_y;
    logic signed [SAT_IN_W-1:0] adv_sum;
    logic signed [SAT_IN_W-1:0] line_sum;
    logic signed [POS_W-1:0]    scr_x_reg;
    logic signed [POS_W-1:0]    scr_y_reg;
    logic        [POS_W-1:0]    scr_w_reg;
    logic        [POS_W-1:0]    scr_h_reg;
    logic        [ATLAS_W-1:0]  atl_x_reg;
    logic        [ATLAS_W-1:0]  atl_y_reg;
    logic        [SIZE_W-1:0]   atl_w_reg;
    logic        [SIZE_W-1:0]   atl_h_reg;

    // Items without a quad never wait on the output side
    assign quad_free = !out_valid_reg || quad.ready;
    assign sc_fire   = sc.valid && ((sc.op != OP_GLYPH) || quad_free);
    assign sc_take   = !sc.valid || sc_fire;
    assign emit      = sc_fire && (sc.op == OP_GLYPH);

    assign sum_x    = SUM_W'(cfg.origin_x) + SUM_W'(pen_x_reg) + SUM_W'(sc.prod_x);
    assign sum_y    = SUM_W'(cfg.origin_y) + SUM_W'(pen_y_reg) + SUM_W'(sc.prod_y);
    assign adv_sum  = SAT_IN_W'(pen_x_reg) + $signed(SAT_IN_W'(sc.adv_prod));
    assign line_sum = SAT_IN_W'(pen_y_reg) + $signed(SAT_IN_W'(cfg.line_step));

    always_comb
    begin
        pen_x_next = pen_x_reg;
        pen_y_next = pen_y_reg;
        if (sc_fire)
        begin
            case (sc.op)
                OP_START:
                begin
                    pen_x_next = '0;
                    pen_y_next = '0;
                end
                OP_NEWLINE:
                begin
                    pen_x_next = '0;
                    pen_y_next = sat_pos(line_sum);
                end
                OP_SPACE, OP_TAB, OP_GLYPH: pen_x_next = sat_pos(adv_sum);
                default:
                begin
                    pen_x_next = pen_x_reg;
                    pen_y_next = pen_y_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !quad.ready;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_x_reg     <= '0;
            pen_y_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pen_x_reg     <= pen_x_next;
            pen_y_reg     <= pen_y_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            scr_x_reg <= sat_pos(SAT_IN_W'(sum_x));
            scr_y_reg <= sat_pos(SAT_IN_W'(sum_y));
            scr_w_reg <= sc.size_w;
            scr_h_reg <= sc.size_h;
            atl_x_reg <= sc.atlas_x;
            atl_y_reg <= sc.atlas_y;
            atl_w_reg <= sc.atlas_w;
            atl_h_reg <= sc.atlas_h;
        end
    end

    assign quad.valid    = out_valid_reg;
    assign quad.screen_x = scr_x_reg;
    assign quad.screen_y = scr_y_reg;
    assign quad.screen_w = scr_w_reg;
    assign quad.screen_h = scr_h_reg;
    assign quad.atlas_x  = atl_x_reg;
    assign quad.atlas_y  = atl_y_reg;
    assign quad.atlas_w  = atl_w_reg;
    assign quad.atlas_h  = atl_h_reg;

    `BFTL_ASSERT(a_start_clears_pen,
        sc_fire && sc.op == OP_START |=> pen_x_reg == '0 && pen_y_reg == '0,
        "pen not cleared after start")
    `BFTL_ASSERT(a_newline_returns,
        sc_fire && sc.op == OP_NEWLINE |=> pen_x_reg == '0,
        "pen x not returned after newline")
    `BFTL_ASSERT(a_quad_from_glyph,
        $rose(out_valid_reg) |-> $past(sc.valid && sc.op == OP_GLYPH),
        "quad raised without a glyph item")
    `BFTL_ASSERT(a_no_quad_never_waits,
        sc.valid && sc.op != OP_GLYPH |-> sc_take,
        "item without quad held in scale stage")
endmodule

// File: rtl/core/bitmap_font_text_layout_unit.sv
// Top level of the bitmap font text layout unit.
//
// Channels: req carries load, start and character requests; quad returns one
// screen quad with its atlas rectangle for each printable character; cfg writes
// origin_x, origin_y, glyph_scale, advance_scale and line_step (indexes 0..4)
// and is always ready. Write cfg only while the unit is idle.
// A character's quad passes the glyph table read, the scaling multiplies and
// the placement add and clamp, and waits in the output register until quad
// takes it. Throughput: one request per cycle while req is ready; the glyph
// table takes one write or one read per cycle and the pen update sits in the
// single placement stage.
// Space, tab, newline and start move only the pen; loads only write the table.
// Reset clears the pen, restores the register defaults and marks every glyph
// entry unwritten so that it reads as zero, all at once with no sweep.
// When quad stalls, the quad waits in the output register; requests without a
// quad keep flowing past it, and req drops ready once the stages behind a held
// character fill up.
module bitmap_font_text_layout_unit
    import bftl_pkg::*;
#(
    parameter int GLYPH_COUNT = GLYPH_COUNT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    bftl_req_if.sink    req,
    bftl_quad_if.source quad,
    bftl_cfg_if.sink    cfg
);
    cfg_t cfg_reg;
    lk_t  lk;
    sc_t  sc;
    logic lk_take;
    logic sc_take;

    // Configuration writes complete in a single transfer
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_x      <= '0;
            cfg_reg.origin_y      <= '0;
            cfg_reg.glyph_scale   <= GLYPH_SCALE_RST;
            cfg_reg.advance_scale <= ADVANCE_SCALE_RST;
            cfg_reg.line_step     <= LINE_STEP_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_ORIGIN_X:      cfg_reg.origin_x      <= cfg.data[POS_W-1:0];
                CFG_ORIGIN_Y:      cfg_reg.origin_y      <= cfg.data[POS_W-1:0];
                CFG_GLYPH_SCALE:   cfg_reg.glyph_scale   <= cfg.data[SCALE_W-1:0];
                CFG_ADVANCE_SCALE: cfg_reg.advance_scale <= cfg.data[SCALE_W-1:0];
                CFG_LINE_STEP:     cfg_reg.line_step     <= cfg.data[STEP_W-1:0];
                // Drop writes to unused indexes
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Stage 1: decode, write loads, read the glyph (or underscore) entry
    bftl_lookup #(
        .GLYPH_COUNT (GLYPH_COUNT)
    ) u_lookup (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .lk_take (lk_take),
        .lk      (lk)
    );

    // Stage 2: multiply offsets, sizes and advance by the scales
    bftl_scale u_scale (
        .clk     (clk),
        .rst_n   (rst_n),
        .lk      (lk),
        .lk_take (lk_take),
        .cfg     (cfg_reg),
        .sc      (sc),
        .sc_take (sc_take)
    );

    // Stage 3: add pen and origin, clamp, advance the pen, hold the quad
    bftl_place u_place (
        .clk     (clk),
        .rst_n   (rst_n),
        .sc      (sc),
        .sc_take (sc_take),
        .cfg     (cfg_reg),
        .quad    (quad)
    );
endmodule
